/* rtl/lod_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lod_pkg
// Shared types and thresholds of the lift-off detector.
// ----------------------------------------------------------------------------
package lod_pkg;

  // near-still: |left| + |right| below this
  localparam logic [17:0] STILL_LIMIT     = 18'd50;
  // phase 0 leaves once the still count exceeds this
  localparam logic [3:0]  STILL_TICKS_MIN = 4'd10;
  // phase 1 gives up once its count exceeds this
  localparam logic [7:0]  LIFT_TIMEOUT    = 8'd200;
  localparam logic signed [15:0] ACCEL_LIMIT = 16'sd22000;
  // half width of the angle window in whole degrees
  localparam logic signed [17:0] ANGLE_WINDOW = 18'sd20;
  localparam int unsigned ANGLE_FRAC_BITS = 8;
  // phase 2 gives up once its count exceeds this
  localparam logic [6:0]  SPIN_TIMEOUT    = 7'd100;
  // wheel spin-up: |left + right| above this
  localparam logic [17:0] SPIN_LIMIT      = 18'd50;

  typedef enum logic [2:0] {
    PH_STILL = 3'b001,
    PH_LIFT  = 3'b010,
    PH_SPIN  = 3'b100
  } lod_phase_t;

  // per-item conditions
  typedef struct packed {
    logic still;
    logic lift;
    logic spin;
  } lod_flags_t;

  // detector state as seen from outside
  typedef struct packed {
    lod_phase_t  phase;
    logic [3:0]  still_ticks;
    logic [7:0]  lift_wait_ticks;
    logic [6:0]  spin_wait_ticks;
  } lod_status_t;

endpackage

/* rtl/lod_features.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lod_features
// Sensor conditions of one tick: stillness, lift spike, wheel spin-up.
// ----------------------------------------------------------------------------
module lod_features (
  input  logic signed [15:0] accel_z,
  input  logic signed [16:0] tilt_angle,
  input  logic signed [15:0] left_count,
  input  logic signed [15:0] right_count,
  input  logic signed [7:0]  center_deg,
  output lod_pkg::lod_flags_t flags
);
  import lod_pkg::*;

  logic signed [17:0] left_ext;
  logic signed [17:0] right_ext;
  logic        [17:0] left_abs;
  logic        [17:0] right_abs;
  logic        [17:0] abs_sum;
  logic signed [17:0] wheel_sum;
  logic        [17:0] wheel_abs;
  logic signed [17:0] mid_ext;
  logic signed [17:0] angle_lo;
  logic signed [17:0] angle_hi;
  logic signed [17:0] angle_ext;

  always_comb begin
    left_ext  = {{2{left_count[15]}}, left_count};
    right_ext = {{2{right_count[15]}}, right_count};
    left_abs  = left_ext[17] ? 18'(-left_ext) : 18'(left_ext);
    right_abs = right_ext[17] ? 18'(-right_ext) : 18'(right_ext);
    abs_sum   = left_abs + right_abs;

    wheel_sum = left_ext + right_ext;
    wheel_abs = wheel_sum[17] ? 18'(-wheel_sum) : 18'(wheel_sum);

    mid_ext   = {{10{center_deg[7]}}, center_deg};
    angle_lo  = (mid_ext - ANGLE_WINDOW) <<< ANGLE_FRAC_BITS;
    angle_hi  = (mid_ext + ANGLE_WINDOW) <<< ANGLE_FRAC_BITS;
    angle_ext = {tilt_angle[16], tilt_angle};

    flags.still = abs_sum < STILL_LIMIT;
    flags.lift  = (accel_z > ACCEL_LIMIT) && (angle_ext > angle_lo) && (angle_ext < angle_hi);
    flags.spin  = wheel_abs > SPIN_LIMIT;
  end

endmodule

/* rtl/lod_phase.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lod_phase
// Three-phase detector state and its per-tick update, phases fall through.
// ----------------------------------------------------------------------------
module lod_phase (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  lod_pkg::lod_flags_t  flags,
  output logic                 hit,
  output lod_pkg::lod_status_t status
);
  import lod_pkg::*;

  lod_phase_t phase_r, phase_nxt;
  logic [3:0] still_r, still_nxt;
  logic [7:0] lift_r,  lift_nxt;
  logic [6:0] spin_r,  spin_nxt;

  always_comb begin
    phase_nxt = phase_r;
    still_nxt = still_r;
    lift_nxt  = lift_r;
    spin_nxt  = spin_r;
    hit       = 1'b0;

    if (phase_nxt == PH_STILL) begin
      still_nxt = flags.still ? 4'(still_r + 4'd1) : 4'd0;
      if (still_nxt > STILL_TICKS_MIN) begin
        still_nxt = 4'd0;
        phase_nxt = PH_LIFT;
      end
    end
    if (phase_nxt == PH_LIFT) begin
      lift_nxt = 8'(lift_r + 8'd1);
      if (lift_nxt > LIFT_TIMEOUT) begin
        lift_nxt  = 8'd0;
        phase_nxt = PH_STILL;
      end
      if (flags.lift) begin
        phase_nxt = PH_SPIN;
      end
    end
    if (phase_nxt == PH_SPIN) begin
      spin_nxt = 7'(spin_r + 7'd1);
      if (spin_nxt > SPIN_TIMEOUT) begin
        spin_nxt  = 7'd0;
        phase_nxt = PH_STILL;
      end
      if (flags.spin) begin
        phase_nxt = PH_STILL;
        hit       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_STILL;
      still_r <= '0;
      lift_r  <= '0;
      spin_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      still_r <= still_nxt;
      lift_r  <= lift_nxt;
      spin_r  <= spin_nxt;
    end
  end

  assign status.phase           = phase_r;
  assign status.still_ticks     = still_r;
  assign status.lift_wait_ticks = lift_r;
  assign status.spin_wait_ticks = spin_r;

endmodule

/* rtl/lift_off_detector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lift_off_detector
// Detects that a balancing vehicle has been picked up from the ground.
//
// One input transfer is one control tick (acceleration, tilt, two encoder
// counts); every tick gives exactly one result transfer with picked_up.
// Input and result channels use valid/ready. An item is held in the input
// register and is then folded into the detector state and written to the
// result register once that register is empty or being read; out_valid
// is set as the result is written. Throughput is one item per cycle, with
// one state update per tick, while the receiver does not stall. A new item
// is taken while a result waits, as long as the input register can move
// on; when the receiver stalls, the result register holds and the input
// register fills, then in_ready drops.
// cfg_we writes the balance center angle; write it only while idle.
// Synchronous reset clears the phase, all counters, the center angle and
// both valid flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lift_off_detector (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic signed [7:0]  cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_accel_z,
  input  logic signed [16:0] in_tilt_angle,
  input  logic signed [15:0] in_left_count,
  input  logic signed [15:0] in_right_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_picked_up
);
  import lod_pkg::*;

  logic signed [7:0]  center_deg_r;
  logic               s1_valid_r;
  logic signed [15:0] accel_r;
  logic signed [16:0] angle_r;
  logic signed [15:0] left_r;
  logic signed [15:0] right_r;
  logic               out_valid_r;
  logic               picked_r;
  logic               advance;
  logic               hit;
  lod_flags_t         flags;
  lod_status_t        status;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_deg_r <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        center_deg_r <= cfg_wdata;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      accel_r <= in_accel_z;
      angle_r <= in_tilt_angle;
      left_r  <= in_left_count;
      right_r <= in_right_count;
    end
    if (advance) begin
      picked_r <= hit;
    end
  end

  lod_features u_features (
    .accel_z     (accel_r),
    .tilt_angle  (angle_r),
    .left_count  (left_r),
    .right_count (right_r),
    .center_deg  (center_deg_r),
    .flags       (flags)
  );

  lod_phase u_phase (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .flags  (flags),
    .hit    (hit),
    .status (status)
  );

  assign out_valid     = out_valid_r;
  assign out_picked_up = picked_r;

`ifndef ASSERT_OFF
  a_still_bound: assert property (@(posedge clk) disable iff (!rst_n)
    status.still_ticks <= STILL_TICKS_MIN)
    else $error("still count beyond its limit");

  a_lift_bound: assert property (@(posedge clk) disable iff (!rst_n)
    status.lift_wait_ticks <= LIFT_TIMEOUT)
    else $error("lift wait count beyond timeout");

  a_spin_bound: assert property (@(posedge clk) disable iff (!rst_n)
    status.spin_wait_ticks <= SPIN_TIMEOUT)
    else $error("spin wait count beyond timeout");

  a_hit_from_armed: assert property (@(posedge clk) disable iff (!rst_n)
    advance && hit |-> status.phase == PH_LIFT || status.phase == PH_SPIN)
    else $error("pickup reported from still phase");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r)
    else $error("held tick dropped");
`endif

endmodule
